### rtl/core/bsp_pkg.sv
// shared types, constants and rounding helpers for the bezier spline point evaluator
// no dependencies

package bsp_pkg;

    // item function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_EVAL  = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINTS_IN_USE = 2'd1;

    // angle units
    localparam logic [14:0] QUARTER_TURN = 15'd5760;
    localparam logic [14:0] FULL_TURN    = 15'd23040;

    // quarter-wave sine: reciprocal of 5760/2^30 scaled by 2^18, then taylor coefficients
    localparam logic [35:0] SIN_RECIP = 36'd48867183457;
    localparam logic [30:0] SIN_C0 = 31'd1686629713;
    localparam logic [30:0] SIN_C1 = 31'd693598668;
    localparam logic [30:0] SIN_C2 = 31'd85569306;
    localparam logic [30:0] SIN_C3 = 31'd5026995;
    localparam logic [17:0] SIN_C4 = 18'd172272;

    // datapath widths
    localparam int PW  = 18;   // control and intermediate point width, signed
    localparam int DW  = PW + 1;
    localparam int TW  = 17;   // t in q1.16, 0..65536
    localparam int PRW = DW + TW + 1;
    localparam int OW  = 17;   // handle offset width, signed

    // unit latencies
    localparam int SIN_LAT    = 8;
    localparam int DIV_STAGES = 9;
    localparam int BZ_LAT     = 7;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] angle;
        logic [13:0]        len;
    } anchor_t;

    typedef struct packed {
        logic valid;
        logic err;
        logic zero;
    } ctrl_t;

    // (b - a) * t
    function automatic logic signed [PRW-1:0] mix_mul(input logic signed [PW-1:0] a,
                                                      input logic signed [PW-1:0] b,
                                                      input logic [TW-1:0] t);
        logic signed [DW-1:0] diff;
        diff = DW'(b) - DW'(a);
        return PRW'(diff) * PRW'(signed'({1'b0, t}));
    endfunction

    // a + product / 2^16, rounded half away from zero
    function automatic logic signed [PW-1:0] mix_add(input logic signed [PW-1:0] a,
                                                     input logic signed [PRW-1:0] prod);
        logic             neg;
        logic [PRW-1:0]   mag;
        logic [PRW-1:0]   rmag;
        logic signed [PRW-1:0] rs;
        neg  = prod[PRW-1];
        mag  = neg ? PRW'(-prod) : PRW'(prod);
        rmag = (mag + PRW'(32768)) >> 16;
        rs   = neg ? -signed'(rmag) : signed'(rmag);
        return a + PW'(rs);
    endfunction

endpackage

### rtl/core/bsp_sine.sv
// pipelined quarter-wave sine of a reduced angle, q1.14 result
// uses bsp_pkg

module bsp_sine
(
    input  logic               clk,
    input  logic [14:0]        angle_r,
    output logic signed [15:0] sine
);
    import bsp_pkg::*;

    logic [1:0]  quad;
    logic [12:0] phase;
    logic [12:0] phase_m;
    logic [48:0] xp;
    logic [61:0] sq;
    logic [48:0] m1;
    logic [61:0] m2;
    logic [61:0] m3;
    logic [61:0] m4;
    logic [61:0] m5;
    logic [31:0] rnd;
    logic [15:0] mag;

    logic [30:0] x1_reg, x2_reg, x3_reg, x4_reg, x5_reg, x6_reg;
    logic [30:0] sq2_reg, sq3_reg, sq4_reg, sq5_reg;
    logic [30:0] acc3_reg, acc4_reg, acc5_reg, acc6_reg, acc7_reg;
    logic [7:1]  neg_reg;
    logic signed [15:0] sine_reg;

    always_comb
    begin
        if (angle_r >= 15'(3 * QUARTER_TURN))
        begin
            quad  = 2'd3;
            phase = 13'(angle_r - 15'(3 * QUARTER_TURN));
        end
        else if (angle_r >= 15'(2 * QUARTER_TURN))
        begin
            quad  = 2'd2;
            phase = 13'(angle_r - 15'(2 * QUARTER_TURN));
        end
        else if (angle_r >= QUARTER_TURN)
        begin
            quad  = 2'd1;
            phase = 13'(angle_r - QUARTER_TURN);
        end
        else
        begin
            quad  = 2'd0;
            phase = 13'(angle_r);
        end
        // odd quadrants run the quarter wave backwards
        phase_m = quad[0] ? 13'(QUARTER_TURN) - phase : phase;
        xp  = 49'(phase_m) * 49'(SIN_RECIP);
        sq  = 62'(x1_reg) * 62'(x1_reg);
        m1  = 49'(sq2_reg) * 49'(SIN_C4);
        m2  = 62'(sq3_reg) * 62'(acc3_reg);
        m3  = 62'(sq4_reg) * 62'(acc4_reg);
        m4  = 62'(sq5_reg) * 62'(acc5_reg);
        m5  = 62'(x6_reg) * 62'(acc6_reg);
        rnd = (32'(acc7_reg) + 32'd32768) >> 16;
        mag = (rnd > 32'd16384) ? 16'd16384 : rnd[15:0];
    end

    always_ff @(posedge clk)
    begin
        x1_reg     <= xp[48:18];
        neg_reg[1] <= quad[1];

        sq2_reg    <= sq[60:30];
        x2_reg     <= x1_reg;

        acc3_reg   <= SIN_C3 - 31'(m1[48:30]);
        sq3_reg    <= sq2_reg;
        x3_reg     <= x2_reg;

        acc4_reg   <= SIN_C2 - 31'(m2[61:30]);
        sq4_reg    <= sq3_reg;
        x4_reg     <= x3_reg;

        acc5_reg   <= SIN_C1 - 31'(m3[61:30]);
        sq5_reg    <= sq4_reg;
        x5_reg     <= x4_reg;

        acc6_reg   <= SIN_C0 - 31'(m4[61:30]);
        x6_reg     <= x5_reg;

        acc7_reg   <= 31'(m5[61:30]);

        for (int k = 2; k <= 7; k++)
        begin
            neg_reg[k] <= neg_reg[k-1];
        end

        sine_reg <= neg_reg[7] ? -signed'(mag) : signed'(mag);
    end

    assign sine = sine_reg;

endmodule

### rtl/core/bsp_tdiv.sv
// pipelined restoring divider for t = (step * 2^16 + res / 2) / res, two bits a stage, one in the last
// uses bsp_pkg

module bsp_tdiv
(
    input  logic          clk,
    input  logic [8:0]    step,
    input  logic [8:0]    res,
    output logic [16:0]   t
);
    import bsp_pkg::*;

    logic [8:0]    rem_in  [DIV_STAGES];
    logic [TW-1:0] num_in  [DIV_STAGES];
    logic [TW-1:0] quo_in  [DIV_STAGES];
    logic [8:0]    den_in  [DIV_STAGES];
    logic [8:0]    rem_out [DIV_STAGES];
    logic [TW-1:0] quo_out [DIV_STAGES];
    logic [8:0]    rem_reg [DIV_STAGES];
    logic [TW-1:0] num_reg [DIV_STAGES];
    logic [TW-1:0] quo_reg [DIV_STAGES];
    logic [8:0]    den_reg [DIV_STAGES];

    // numerator low bits: step lsb, then zeros, then half the divisor
    assign rem_in[0] = {1'b0, step[8:1]};
    assign num_in[0] = {step[0], 8'd0, res[8:1]};
    assign quo_in[0] = '0;
    assign den_in[0] = res;

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        localparam int NB = (s == DIV_STAGES - 1) ? (TW - 2 * s) : 2;
        logic [9:0]    trial;
        logic [8:0]    rem_w;
        logic [TW-1:0] quo_w;

        if (s > 0)
        begin : g_link
            assign rem_in[s] = rem_reg[s-1];
            assign num_in[s] = num_reg[s-1];
            assign quo_in[s] = quo_reg[s-1];
            assign den_in[s] = den_reg[s-1];
        end

        always_comb
        begin
            rem_w = rem_in[s];
            quo_w = quo_in[s];
            trial = '0;
            for (int j = 0; j < NB; j++)
            begin
                trial = {rem_w, num_in[s][TW-1-2*s-j]};
                if (trial >= {1'b0, den_in[s]})
                begin
                    rem_w = 9'(trial - {1'b0, den_in[s]});
                    quo_w[TW-1-2*s-j] = 1'b1;
                end
                else
                begin
                    rem_w = trial[8:0];
                end
            end
            rem_out[s] = rem_w;
            quo_out[s] = quo_w;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s] <= rem_out[s];
            quo_reg[s] <= quo_out[s];
            num_reg[s] <= num_in[s];
            den_reg[s] <= den_in[s];
        end
    end

    assign t = quo_reg[DIV_STAGES-1];

endmodule

### rtl/core/bsp_bezier.sv
// pipelined cubic de casteljau for one coordinate with saturation to 16 bits
// uses bsp_pkg

module bsp_bezier
(
    input  logic                  clk,
    input  logic signed [17:0]    p0,
    input  logic signed [17:0]    p1,
    input  logic signed [17:0]    p2,
    input  logic signed [17:0]    p3,
    input  logic [16:0]           t,
    output logic signed [15:0]    q
);
    import bsp_pkg::*;

    logic signed [PRW-1:0] pa_reg, pb_reg, pc_reg, pd_reg, pe_reg, pf_reg;
    logic signed [PW-1:0]  ba_reg, bb_reg, bc_reg, bd_reg, be_reg, bf_reg;
    logic signed [PW-1:0]  la_reg, lb_reg, lc_reg, ld_reg, le_reg, lf_reg;
    logic [TW-1:0]         t1_reg, t2_reg, t3_reg, t4_reg;
    logic signed [15:0]    q_reg;

    always_ff @(posedge clk)
    begin
        // first level
        pa_reg <= mix_mul(p0, p1, t);
        pb_reg <= mix_mul(p1, p2, t);
        pc_reg <= mix_mul(p2, p3, t);
        ba_reg <= p0;
        bb_reg <= p1;
        bc_reg <= p2;
        t1_reg <= t;

        la_reg <= mix_add(ba_reg, pa_reg);
        lb_reg <= mix_add(bb_reg, pb_reg);
        lc_reg <= mix_add(bc_reg, pc_reg);
        t2_reg <= t1_reg;

        // second level
        pd_reg <= mix_mul(la_reg, lb_reg, t2_reg);
        pe_reg <= mix_mul(lb_reg, lc_reg, t2_reg);
        bd_reg <= la_reg;
        be_reg <= lb_reg;
        t3_reg <= t2_reg;

        ld_reg <= mix_add(bd_reg, pd_reg);
        le_reg <= mix_add(be_reg, pe_reg);
        t4_reg <= t3_reg;

        // last level
        pf_reg <= mix_mul(ld_reg, le_reg, t4_reg);
        bf_reg <= ld_reg;

        lf_reg <= mix_add(bf_reg, pf_reg);

        if (lf_reg > PW'(32767))
        begin
            q_reg <= 16'sd32767;
        end
        else if (lf_reg < -PW'(32768))
        begin
            q_reg <= -16'sd32768;
        end
        else
        begin
            q_reg <= 16'(lf_reg);
        end
    end

    assign q = q_reg;

endmodule

### rtl/core/bezier_spline_point_evaluator_core.sv
// top level of the bezier spline point evaluator: anchor memory, control pipeline
// depends on bsp_pkg, bsp_sine, bsp_tdiv, bsp_bezier

// usage
// - a word is accepted on a rising edge with start high and busy low; busy stays low,
//   so a new word may be given every cycle
// - func selects the job: an anchor write stores pos_x, pos_y, angle and handle_len
//   at point_index; an evaluate word names a segment and a step on it
// - every accepted word gives exactly one result word: done is high for one cycle with
//   curve_x, curve_y and error; a write gives zeros, a bad evaluate gives error high
// - both kinds of word travel the same pipeline from the accepting edge to the result;
//   throughput is one word per cycle
// - the rate comes from the anchor memory: one write port and two read ports, so
//   both end anchors of a segment are fetched in the accepting cycle
// - an evaluate word sees every anchor write accepted before it
// - the receiver cannot stall; results leave on the cycle they are ready
// - configuration goes through the cfg channel (cfg_ready is always high) and must
//   only be written with no word in flight
// - reset clears the pipeline valid bits and loads the register defaults; the anchor
//   memory is not cleared and holds garbage until written

module bezier_spline_point_evaluator_core #(
    parameter int MAX_POINTS = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // command channel
    input  logic                              start,
    output logic                              busy,
    input  logic                              func,
    input  logic [3:0]                        point_index,
    input  logic signed [15:0]                pos_x,
    input  logic signed [15:0]                pos_y,
    input  logic signed [15:0]                angle,
    input  logic [13:0]                       handle_len,
    input  logic [3:0]                        segment,
    input  logic [8:0]                        step,
    // result channel
    output logic                              done,
    output logic signed [15:0]                curve_x,
    output logic signed [15:0]                curve_y,
    output logic                              error,
    // configuration channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bsp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [8:0]                        cfg_data
);
    import bsp_pkg::*;

    localparam int AW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
    localparam logic [8:0] MAXP9 = 9'(MAX_POINTS);

    // pipeline stage numbers; the accepting edge loads the first stage
    localparam int S_RD  = 1;                       // memory read data
    localparam int S_RED = 2;                       // reduced angles
    localparam int S_OFF = S_RED + SIN_LAT + 1;     // handle offsets
    localparam int S_CP  = S_OFF + 1;               // control points
    localparam int S_OUT = S_CP + BZ_LAT;           // result

    // configuration registers
    logic [8:0] res_reg;
    logic [4:0] piu_reg;

    // command decode
    logic       accept;
    logic [8:0] idx9;
    logic [8:0] seg9;
    logic [8:0] segn9;
    logic [8:0] used9;
    logic       bad;
    logic       mem_we;

    // anchor memory, two read ports
    anchor_t    anchor_mem [MAX_POINTS];
    anchor_t    rd_a_reg;
    anchor_t    rd_b_reg;

    // control line
    ctrl_t      ctrl_d [1:S_OUT];

    // anchor data line
    anchor_t    a_d [S_RED:S_OFF];
    anchor_t    b_d [S_RED:S_OFF];

    // angle reduction
    logic [14:0] ra_reg, rca_reg, rb_reg, rcb_reg;
    logic signed [15:0] sin_a, cos_a, sin_b, cos_b;

    // handle offsets
    logic signed [OW-1:0] dxa_reg, dya_reg, dxb_reg, dyb_reg;

    // control points
    logic signed [PW-1:0] px0_reg, px1_reg, px2_reg, px3_reg;
    logic signed [PW-1:0] py0_reg, py1_reg, py2_reg, py3_reg;

    // t line
    logic [TW-1:0] t_div;
    logic [TW-1:0] t_d [DIV_STAGES+1:S_CP];

    logic signed [15:0] bz_x, bz_y;

    // angle in 1/64 degree reduced to one turn
    function automatic logic [14:0] wrap_angle(input logic signed [15:0] ang);
        logic signed [16:0] a17;
        logic signed [16:0] r;
        a17 = 17'(ang);
        if (a17 < -17'sd23040)
        begin
            r = a17 + 17'sd46080;
        end
        else if (a17 < 17'sd0)
        begin
            r = a17 + 17'sd23040;
        end
        else if (a17 >= 17'sd23040)
        begin
            r = a17 - 17'sd23040;
        end
        else
        begin
            r = a17;
        end
        return r[14:0];
    endfunction

    // quarter turn ahead, so the sine unit yields the cosine
    function automatic logic [14:0] quarter_ahead(input logic [14:0] r);
        logic [15:0] s;
        s = 16'(r) + 16'(QUARTER_TURN);
        if (s >= 16'(FULL_TURN))
        begin
            s = s - 16'(FULL_TURN);
        end
        return s[14:0];
    endfunction

    // length * sine / 2^14, rounded half away from zero
    function automatic logic signed [OW-1:0] handle_off(input logic [13:0] len,
                                                        input logic signed [15:0] sn);
        logic signed [30:0] prod;
        logic               neg;
        logic [30:0]        mag;
        logic [30:0]        rmag;
        prod = 31'(signed'({1'b0, len})) * 31'(sn);
        neg  = prod[30];
        mag  = neg ? 31'(-prod) : 31'(prod);
        rmag = (mag + 31'd8192) >> 14;
        return neg ? -OW'(signed'(rmag)) : OW'(signed'(rmag));
    endfunction

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // segment check uses live registers; keeping config stable while words are in flight is up to the user
    assign idx9  = {5'd0, point_index};
    assign seg9  = {5'd0, segment};
    assign segn9 = seg9 + 9'd1;
    assign used9 = ({4'd0, piu_reg} < MAXP9) ? {4'd0, piu_reg} : MAXP9;
    assign bad   = (res_reg == 9'd0) || (step > res_reg) || (segn9 >= used9);
    assign mem_we = accept && (func == FUNC_WRITE) && (idx9 < MAXP9);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= 9'd20;
            piu_reg <= 5'd2;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_RESOLUTION:    res_reg <= cfg_data;
                REG_POINTS_IN_USE: piu_reg <= cfg_data[4:0];
                default:           ;
            endcase
        end
    end

    // anchor memory: write on anchor words, read both segment ends every cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            anchor_mem[idx9[AW-1:0]] <= '{x: pos_x, y: pos_y, angle: angle, len: handle_len};
        end
        rd_a_reg <= anchor_mem[seg9[AW-1:0]];
        rd_b_reg <= anchor_mem[segn9[AW-1:0]];
    end

    // control line: valid, error and zero-result flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= S_OUT; k++)
            begin
                ctrl_d[k] <= '0;
            end
        end
        else
        begin
            ctrl_d[1].valid <= accept;
            ctrl_d[1].err   <= accept && (func == FUNC_EVAL) && bad;
            ctrl_d[1].zero  <= (func == FUNC_WRITE) || bad;
            for (int k = 2; k <= S_OUT; k++)
            begin
                ctrl_d[k] <= ctrl_d[k-1];
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        // angle reduction
        ra_reg  <= wrap_angle(rd_a_reg.angle);
        rb_reg  <= wrap_angle(rd_b_reg.angle);
        rca_reg <= quarter_ahead(wrap_angle(rd_a_reg.angle));
        rcb_reg <= quarter_ahead(wrap_angle(rd_b_reg.angle));

        // anchors follow the sine units
        a_d[S_RED] <= rd_a_reg;
        b_d[S_RED] <= rd_b_reg;
        for (int k = S_RED + 1; k <= S_OFF; k++)
        begin
            a_d[k] <= a_d[k-1];
            b_d[k] <= b_d[k-1];
        end

        // handle offsets
        dxa_reg <= handle_off(a_d[S_OFF-1].len, cos_a);
        dya_reg <= handle_off(a_d[S_OFF-1].len, sin_a);
        dxb_reg <= handle_off(b_d[S_OFF-1].len, cos_b);
        dyb_reg <= handle_off(b_d[S_OFF-1].len, sin_b);

        // control points: a, a + handle, b - handle, b
        px0_reg <= PW'(a_d[S_OFF].x);
        px1_reg <= PW'(a_d[S_OFF].x) + PW'(dxa_reg);
        px2_reg <= PW'(b_d[S_OFF].x) - PW'(dxb_reg);
        px3_reg <= PW'(b_d[S_OFF].x);
        py0_reg <= PW'(a_d[S_OFF].y);
        py1_reg <= PW'(a_d[S_OFF].y) + PW'(dya_reg);
        py2_reg <= PW'(b_d[S_OFF].y) - PW'(dyb_reg);
        py3_reg <= PW'(b_d[S_OFF].y);

        // t waits for the control points
        t_d[DIV_STAGES+1] <= t_div;
        for (int k = DIV_STAGES + 2; k <= S_CP; k++)
        begin
            t_d[k] <= t_d[k-1];
        end
    end

    bsp_tdiv u_tdiv
    (
        .clk  (clk),
        .step (step),
        .res  (res_reg),
        .t    (t_div)
    );

    bsp_sine u_sin_a (.clk(clk), .angle_r(ra_reg),  .sine(sin_a));
    bsp_sine u_cos_a (.clk(clk), .angle_r(rca_reg), .sine(cos_a));
    bsp_sine u_sin_b (.clk(clk), .angle_r(rb_reg),  .sine(sin_b));
    bsp_sine u_cos_b (.clk(clk), .angle_r(rcb_reg), .sine(cos_b));

    bsp_bezier u_bz_x
    (
        .clk (clk),
        .p0  (px0_reg),
        .p1  (px1_reg),
        .p2  (px2_reg),
        .p3  (px3_reg),
        .t   (t_d[S_CP]),
        .q   (bz_x)
    );

    bsp_bezier u_bz_y
    (
        .clk (clk),
        .p0  (py0_reg),
        .p1  (py1_reg),
        .p2  (py2_reg),
        .p3  (py3_reg),
        .t   (t_d[S_CP]),
        .q   (bz_y)
    );

    // writes and rejected evaluates give zero coordinates
    assign done    = ctrl_d[S_OUT].valid;
    assign error   = ctrl_d[S_OUT].err;
    assign curve_x = ctrl_d[S_OUT].zero ? 16'sd0 : bz_x;
    assign curve_y = ctrl_d[S_OUT].zero ? 16'sd0 : bz_y;

endmodule

### test/bezier_spline_point_evaluator_core_tb.sv
// testbench for bezier_spline_point_evaluator_core: anchor writes and curve evaluations
// checked against a cycle-free predictor held in a small scoreboard class
// depends on bsp_pkg and the core rtl
`timescale 1ns / 1ps

module bezier_spline_point_evaluator_core_tb;

    import bsp_pkg::*;

    // register indexes that decode to nothing
    localparam logic [CFG_IDX_W-1:0] REG_NONE  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;
    localparam int NUM_ANCHORS   = 16;
    localparam int STALL_LIMIT   = 4000;
    localparam int PIPE_LATENCY  = 19;

    // one command word
    typedef struct {
        logic        fn;
        logic [3:0]  idx;
        logic [15:0] px;
        logic [15:0] py;
        logic [15:0] ang;
        logic [13:0] len;
        logic [3:0]  seg;
        logic [8:0]  stp;
    } cmd_t;

    // one result word
    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        logic        err;
    } point_t;

    // predictor of the curve math plus the queue of points still to come
    class curve_scoreboard;
        int unsigned steps_per_seg;
        int unsigned anchors_used;
        longint      ax [NUM_ANCHORS];
        longint      ay [NUM_ANCHORS];
        int          hang [NUM_ANCHORS];
        longint      hlen [NUM_ANCHORS];
        point_t      pending [$];
        int          errors;
        int          checked;
        int          evals_ok;
        int          evals_bad;

        function new();
            steps_per_seg = 20;
            anchors_used  = 2;
            errors        = 0;
            checked       = 0;
            evals_ok      = 0;
            evals_bad     = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [8:0] data);
            if (idx == REG_RESOLUTION)
                steps_per_seg = 32'(data);
            else if (idx == REG_POINTS_IN_USE)
                anchors_used = 32'(data[4:0]);
        endfunction

        // divide by 2^s, rounded half away from zero
        function longint shr_round(longint v, int s);
            longint h;
            h = longint'(1) << (s - 1);
            if (v >= 0)
                return (v + h) >> s;
            return -((-v + h) >> s);
        endfunction

        // quarter-wave sine in q1.14 for a phase of 0..5760
        function longint quarter_sin(longint unsigned p);
            longint unsigned x, x2, acc;
            x   = (p << 30) / 5760;
            x2  = (x * x) >> 30;
            acc = 64'd5026995 - ((x2 * 64'd172272) >> 30);
            acc = 64'd85569306 - ((x2 * acc) >> 30);
            acc = 64'd693598668 - ((x2 * acc) >> 30);
            acc = 64'd1686629713 - ((x2 * acc) >> 30);
            acc = (x * acc) >> 30;
            acc = (acc + 64'd32768) >> 16;
            if (acc > 64'd16384)
                acc = 64'd16384;
            return longint'(acc);
        endfunction

        // sine of an angle already reduced to 0..23039
        function longint turn_sin(int r);
            int q, p;
            q = r / 5760;
            p = r % 5760;
            case (q)
                0:       return quarter_sin(p);
                1:       return quarter_sin(5760 - p);
                2:       return -quarter_sin(p);
                default: return -quarter_sin(5760 - p);
            endcase
        endfunction

        function longint lerp(longint a, longint b, longint t);
            return a + shr_round((b - a) * t, 16);
        endfunction

        function longint casteljau(longint p0, longint p1, longint p2, longint p3, longint t);
            longint a, b, c, d, e;
            a = lerp(p0, p1, t);
            b = lerp(p1, p2, t);
            c = lerp(p2, p3, t);
            d = lerp(a, b, t);
            e = lerp(b, c, t);
            return lerp(d, e, t);
        endfunction

        function logic [15:0] clip16(longint v);
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
            return v[15:0];
        endfunction

        // note an accepted command word and queue the point it must produce
        function void note_cmd(cmd_t c);
            point_t      p;
            int unsigned used;
            longint      t, dxa, dya, dxb, dyb;
            int          ra, rb;
            p.x   = '0;
            p.y   = '0;
            p.err = 1'b0;
            used  = (anchors_used < NUM_ANCHORS) ? anchors_used : NUM_ANCHORS;
            if (c.fn == FUNC_WRITE) begin
                ax[c.idx]   = longint'(signed'(c.px));
                ay[c.idx]   = longint'(signed'(c.py));
                hang[c.idx] = int'(signed'(c.ang));
                hlen[c.idx] = longint'(c.len);
            end
            else if (steps_per_seg == 0 || c.stp > steps_per_seg || c.seg + 1 >= used) begin
                p.err = 1'b1;
                evals_bad++;
            end
            else begin
                t  = ((longint'(c.stp) << 16) + steps_per_seg / 2) / steps_per_seg;
                // handle directions reduced into one turn
                ra = hang[c.seg] % 23040;
                if (ra < 0)
                    ra += 23040;
                rb = hang[c.seg + 1] % 23040;
                if (rb < 0)
                    rb += 23040;
                dxa = shr_round(hlen[c.seg] * turn_sin((ra + 5760) % 23040), 14);
                dya = shr_round(hlen[c.seg] * turn_sin(ra), 14);
                dxb = shr_round(hlen[c.seg + 1] * turn_sin((rb + 5760) % 23040), 14);
                dyb = shr_round(hlen[c.seg + 1] * turn_sin(rb), 14);
                p.x = clip16(casteljau(ax[c.seg], ax[c.seg] + dxa,
                                       ax[c.seg + 1] - dxb, ax[c.seg + 1], t));
                p.y = clip16(casteljau(ay[c.seg], ay[c.seg] + dya,
                                       ay[c.seg + 1] - dyb, ay[c.seg + 1], t));
                evals_ok++;
            end
            pending = {pending, p};
        endfunction

        // compare one result word with the oldest pending point
        function void check_point(point_t got);
            point_t want;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result x=%h y=%h err=%b", got.x, got.y, got.err);
                return;
            end
            want = pending.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.err !== want.err) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: want x=%h y=%h err=%b, got x=%h y=%h err=%b",
                             want.x, want.y, want.err, got.x, got.y, got.err);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 func;
    logic [3:0]           point_index;
    logic signed [15:0]   pos_x;
    logic signed [15:0]   pos_y;
    logic signed [15:0]   angle;
    logic [13:0]          handle_len;
    logic [3:0]           segment;
    logic [8:0]           step;
    logic                 done;
    logic signed [15:0]   curve_x;
    logic signed [15:0]   curve_y;
    logic                 error;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [8:0]           cfg_data;

    curve_scoreboard sb;
    int              idle_cycles;
    bit              idling_on;
    int              cur_res;
    int              cur_used;

    bezier_spline_point_evaluator_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .point_index (point_index),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .angle       (angle),
        .handle_len  (handle_len),
        .segment     (segment),
        .step        (step),
        .done        (done),
        .curve_x     (curve_x),
        .curve_y     (curve_y),
        .error       (error),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // monitor: every handshake is taken at the rising edge, before the dut updates
    always @(posedge clk)
    begin
        point_t got;
        cmd_t   c;
        if (rst_n) begin
            if (start && !busy) begin
                c.fn  = func;
                c.idx = point_index;
                c.px  = pos_x;
                c.py  = pos_y;
                c.ang = angle;
                c.len = handle_len;
                c.seg = segment;
                c.stp = step;
                sb.note_cmd(c);
            end
            if (done) begin
                got.x   = curve_x;
                got.y   = curve_y;
                got.err = error;
                sb.check_point(got);
            end
            if (cfg_valid && cfg_ready)
                sb.set_reg(cfg_index, cfg_data);
            // watchdog: any handshake resets the stall count
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // present one word from the falling edge until it is taken; leaves start high
    task automatic send_word(cmd_t c);
        start       <= 1'b1;
        func        <= c.fn;
        point_index <= c.idx;
        pos_x       <= c.px;
        pos_y       <= c.py;
        angle       <= c.ang;
        handle_len  <= c.len;
        segment     <= c.seg;
        step        <= c.stp;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // drop start for a random burst, sometimes
    task automatic maybe_gap();
        if (idling_on && $urandom_range(0, 7) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
    endtask

    // hold the command side until every queued point has come back
    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        // writes also give a result, so the queue empties only once the pipe has drained
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [8:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic cmd_t anchor_word(int idx, int px, int py, int ang, int len);
        cmd_t c;
        c.fn  = FUNC_WRITE;
        c.idx = 4'(idx);
        c.px  = 16'(px);
        c.py  = 16'(py);
        c.ang = 16'(ang);
        c.len = 14'(len);
        c.seg = 4'($urandom);
        c.stp = 9'($urandom);
        return c;
    endfunction

    function automatic cmd_t eval_word(int seg, int stp);
        cmd_t c;
        c.fn  = FUNC_EVAL;
        c.idx = 4'($urandom);
        c.px  = 16'($urandom);
        c.py  = 16'($urandom);
        c.ang = 16'($urandom);
        c.len = 14'($urandom);
        c.seg = 4'(seg);
        c.stp = 9'(stp);
        return c;
    endfunction

    // random traffic: mostly evaluations, most on a real segment when two or more anchors are in use
    function automatic cmd_t random_word();
        int used;
        int pick;
        used = (cur_used < NUM_ANCHORS) ? cur_used : NUM_ANCHORS;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            // anchor rewrite; handle length usually at most 8192, sometimes raw
            return anchor_word($urandom_range(0, NUM_ANCHORS - 1), $urandom, $urandom,
                               $urandom,
                               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383)
                                                           : $urandom_range(0, 8192));
        end
        if (pick < 85 && used >= 2)
            return eval_word($urandom_range(0, used - 2), $urandom_range(0, cur_res));
        return eval_word($urandom_range(0, 15), $urandom_range(0, 511));
    endfunction

    task automatic run_phase(int res, int used, int count, bit gaps);
        drain();
        write_reg(REG_RESOLUTION, 9'(res));
        write_reg(REG_POINTS_IN_USE, 9'(used));
        cur_res   = res;
        cur_used  = used;
        idling_on = gaps;
        for (int i = 0; i < count; i++) begin
            send_word(random_word());
            // one long hold mid-phase so the pipe runs completely dry
            if (gaps && i == count / 2)
                drain();
            else
                maybe_gap();
        end
    endtask

    initial
    begin
        sb          = new();
        idle_cycles = 0;
        idling_on   = 1'b1;
        cur_res     = 20;
        cur_used    = 2;
        rst_n       = 1'b0;
        start       = 1'b0;
        func        = FUNC_WRITE;
        point_index = '0;
        pos_x       = '0;
        pos_y       = '0;
        angle       = '0;
        handle_len  = '0;
        segment     = '0;
        step        = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: fill every anchor, the first nine with extreme positions, angles and lengths
        // and the rest at random, running on the register defaults
        send_word(anchor_word(0, -32768, 32767, -23039, 8192));
        send_word(anchor_word(1, 32767, -32768, 23039, 0));
        send_word(anchor_word(2, 0, 0, 0, 16383));
        send_word(anchor_word(3, 16384, -16384, 5760, 8192));
        send_word(anchor_word(4, -16384, 16384, 11520, 4096));
        send_word(anchor_word(5, 100, -100, 17280, 8192));
        send_word(anchor_word(6, 32767, 32767, -5760, 16383));
        send_word(anchor_word(7, -32768, -32768, 32767, 8192));
        send_word(anchor_word(8, 1, -1, -32768, 1));
        for (int i = 9; i < NUM_ANCHORS; i++)
            send_word(anchor_word(i, $urandom, $urandom, $urandom, $urandom_range(0, 8192)));
        // ends and middle of the segment, step past resolution, bad segments
        send_word(eval_word(0, 0));
        send_word(eval_word(0, 20));
        send_word(eval_word(0, 10));
        send_word(eval_word(0, 21));
        send_word(eval_word(0, 511));
        send_word(eval_word(1, 0));
        send_word(eval_word(15, 5));

        // register sweep, extremes included; out-of-range indexes must be ignored
        drain();
        write_reg(REG_NONE, 9'h1ff);
        write_reg(REG_SPARE, 9'h000);
        run_phase(1, 16, 220, 1'b1);
        run_phase(256, 16, 260, 1'b1);
        run_phase(511, 31, 220, 1'b1);
        run_phase(7, 5, 200, 1'b1);
        run_phase(0, 16, 80, 1'b1);
        run_phase(100, 1, 70, 1'b1);
        run_phase(3, 0, 70, 1'b1);
        run_phase(64, 2, 150, 1'b1);
        // closing stretch at full rate
        run_phase(256, 16, 360, 1'b0);

        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY + 6) @(negedge clk);

        $display("covered %0d result words: %0d in-range evaluations, %0d rejected requests",
                 sb.checked, sb.evals_ok, sb.evals_bad);
        $display("resolution swept 0..511, points in use 0..31, mismatches %0d", sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
